// ===== hw/rtl/tcf_pkg.sv =====
// Shared types, constants and tables of the tilt complementary filter.
package tcf_pkg;

    localparam int CAL_SAMPLES  = 10;
    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_LIMIT  = 11796480;

    localparam int RAW_W  = 10;
    localparam int TICK_W = 8;
    localparam int BIAS_W = 14;
    localparam int CNT_W  = 4;
    localparam int DEV_W  = 16;
    localparam int SQ_W   = 30;
    localparam int RAD_W  = 46;
    localparam int ROOT_W = 23;
    localparam int CX_W   = 27;
    localparam int CZ_W   = 26;
    localparam int ATAN_W = 22;
    localparam int EST_W  = 25;
    localparam int DT_W   = 32;
    localparam int DIV_W  = 33;
    localparam int REM_W  = 4;
    localparam int S_W    = 34;
    localparam int SMAG_W = 33;
    localparam int D_W    = 34;
    localparam int SUM_W  = 36;
    localparam int MUL_W  = 32;

    localparam int DIG_W    = 16;
    localparam int QHI_W    = DIV_W - DIG_W;
    localparam int RECIP_SH = 24;
    localparam int RECIP    = ((1 << RECIP_SH) + CAL_SAMPLES - 1) / CAL_SAMPLES;

    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int DIV_STEPS  = 4;
    localparam int STEP_W     = 6;

    localparam int ZOFF_W  = 10;
    localparam int GAIN_W  = 18;
    localparam int OMEGA_W = 20;
    localparam int TSEC_W  = 24;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_Z_OFFSET     = 2'd0;
    localparam logic [IDX_W-1:0] REG_GYRO_GAIN    = 2'd1;
    localparam logic [IDX_W-1:0] REG_FILTER_OMEGA = 2'd2;
    localparam logic [IDX_W-1:0] REG_TICK_SECONDS = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE, OP_DT, OP_SQ_B, OP_SQ_C, OP_SQRT_LOAD, OP_SQRT, OP_COR_LOAD, OP_COR,
        OP_RATE, OP_DIV_LOAD, OP_DIV, OP_OMEGA, OP_SUM, OP_MUL_LO, OP_MUL_HI, OP_ROUND,
        OP_COMMIT
    } tcf_op_t;

    typedef struct packed {
        logic              load;
        logic              calib;
        tcf_op_t           op;
        logic              axis;
        logic [STEP_W-1:0] step;
        logic              emit;
    } tcf_cmd_t;

    typedef struct packed {
        logic [ZOFF_W-1:0]  z_offset;
        logic [GAIN_W-1:0]  gyro_gain;
        logic [OMEGA_W-1:0] filter_omega;
        logic [TSEC_W-1:0]  tick_seconds;
    } tcf_cfg_t;

    function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/tcf_cfg_regs.sv =====
// Configuration register file of the tilt complementary filter.
module tcf_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [tcf_pkg::IDX_W-1:0]   cfg_wr_index,
    input  logic [tcf_pkg::CFG_W-1:0]   cfg_wr_data,
    output tcf_pkg::tcf_cfg_t           cfg
);

    tcf_pkg::tcf_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.z_offset     <= 10'd576;
            cfg_reg.gyro_gain    <= 18'd47809;
            cfg_reg.filter_omega <= 20'd123532;
            cfg_reg.tick_seconds <= 24'd549756;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                tcf_pkg::REG_Z_OFFSET:
                    cfg_reg.z_offset <= cfg_wr_data[tcf_pkg::ZOFF_W-1:0];
                tcf_pkg::REG_GYRO_GAIN:
                    cfg_reg.gyro_gain <= cfg_wr_data[tcf_pkg::GAIN_W-1:0];
                tcf_pkg::REG_FILTER_OMEGA:
                    cfg_reg.filter_omega <= cfg_wr_data[tcf_pkg::OMEGA_W-1:0];
                tcf_pkg::REG_TICK_SECONDS:
                    cfg_reg.tick_seconds <= cfg_wr_data[tcf_pkg::TSEC_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/tcf_ctrl.sv =====
// Sequencer of the tilt complementary filter: handshakes, calibration count, step control.
module tcf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output tcf_pkg::tcf_cmd_t   cmd
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DT, ST_SQ_B, ST_SQ_C, ST_SQRT_LOAD, ST_SQRT, ST_COR_LOAD, ST_COR,
        ST_RATE, ST_DIV_LOAD, ST_DIV, ST_OMEGA, ST_SUM, ST_MUL_LO, ST_MUL_HI, ST_ROUND,
        ST_COMMIT, ST_EMIT
    } state_t;

    state_t                         state_reg;
    logic [tcf_pkg::STEP_W-1:0]     step_reg;
    logic                           axis_reg;
    logic [tcf_pkg::CNT_W-1:0]      calib_cnt_reg;
    logic                           m_valid_reg;
    logic                           accept;
    logic                           calibrating;
    logic                           emit;
    tcf_pkg::tcf_op_t               op;

    assign s_tready    = (state_reg == ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign calibrating = (calib_cnt_reg < tcf_pkg::CNT_W'(tcf_pkg::CAL_SAMPLES));
    assign emit        = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);
    assign m_tvalid    = m_valid_reg;

    always_comb begin
        unique case (state_reg)
            ST_DT:        op = tcf_pkg::OP_DT;
            ST_SQ_B:      op = tcf_pkg::OP_SQ_B;
            ST_SQ_C:      op = tcf_pkg::OP_SQ_C;
            ST_SQRT_LOAD: op = tcf_pkg::OP_SQRT_LOAD;
            ST_SQRT:      op = tcf_pkg::OP_SQRT;
            ST_COR_LOAD:  op = tcf_pkg::OP_COR_LOAD;
            ST_COR:       op = tcf_pkg::OP_COR;
            ST_RATE:      op = tcf_pkg::OP_RATE;
            ST_DIV_LOAD:  op = tcf_pkg::OP_DIV_LOAD;
            ST_DIV:       op = tcf_pkg::OP_DIV;
            ST_OMEGA:     op = tcf_pkg::OP_OMEGA;
            ST_SUM:       op = tcf_pkg::OP_SUM;
            ST_MUL_LO:    op = tcf_pkg::OP_MUL_LO;
            ST_MUL_HI:    op = tcf_pkg::OP_MUL_HI;
            ST_ROUND:     op = tcf_pkg::OP_ROUND;
            ST_COMMIT:    op = tcf_pkg::OP_COMMIT;
            default:      op = tcf_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        cmd.load  = accept;
        cmd.calib = accept && calibrating;
        cmd.op    = op;
        cmd.axis  = axis_reg;
        cmd.step  = step_reg;
        cmd.emit  = emit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            axis_reg      <= 1'b0;
            calib_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !emit) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (calibrating) begin
                            calib_cnt_reg <= calib_cnt_reg + 1'b1;
                        end else begin
                            axis_reg  <= 1'b0;
                            state_reg <= ST_DT;
                        end
                    end
                end
                ST_DT:        state_reg <= ST_SQ_B;
                ST_SQ_B:      state_reg <= ST_SQ_C;
                ST_SQ_C:      state_reg <= ST_SQRT_LOAD;
                ST_SQRT_LOAD: begin
                    step_reg  <= '0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (step_reg == tcf_pkg::STEP_W'(tcf_pkg::SQRT_STEPS - 1)) begin
                        state_reg <= ST_COR_LOAD;
                    end
                    step_reg <= step_reg + 1'b1;
                end
                ST_COR_LOAD: begin
                    step_reg  <= '0;
                    state_reg <= ST_COR;
                end
                ST_COR: begin
                    if (step_reg == tcf_pkg::STEP_W'(tcf_pkg::CORDIC_STEPS - 1)) begin
                        state_reg <= ST_RATE;
                    end
                    step_reg <= step_reg + 1'b1;
                end
                ST_RATE:      state_reg <= ST_DIV_LOAD;
                ST_DIV_LOAD: begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (step_reg == tcf_pkg::STEP_W'(tcf_pkg::DIV_STEPS - 1)) begin
                        state_reg <= ST_OMEGA;
                    end
                    step_reg <= step_reg + 1'b1;
                end
                ST_OMEGA:     state_reg <= ST_SUM;
                ST_SUM:       state_reg <= ST_MUL_LO;
                ST_MUL_LO:    state_reg <= ST_MUL_HI;
                ST_MUL_HI:    state_reg <= ST_ROUND;
                ST_ROUND:     state_reg <= ST_COMMIT;
                ST_COMMIT: begin
                    if (axis_reg) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        axis_reg  <= 1'b1;
                        state_reg <= ST_SQ_B;
                    end
                end
                ST_EMIT: begin
                    if (emit) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/tcf_datapath.sv =====
// Datapath of the tilt complementary filter: bias, shared multiplier, sqrt, CORDIC, divider.
module tcf_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tcf_pkg::tcf_cmd_t                   cmd,
    input  tcf_pkg::tcf_cfg_t                   cfg,
    input  logic [tcf_pkg::RAW_W-1:0]           accel_x,
    input  logic [tcf_pkg::RAW_W-1:0]           accel_y,
    input  logic [tcf_pkg::RAW_W-1:0]           accel_z,
    input  logic [tcf_pkg::RAW_W-1:0]           rate_x,
    input  logic [tcf_pkg::RAW_W-1:0]           rate_y,
    input  logic [tcf_pkg::TICK_W-1:0]          elapsed_ticks,
    output logic signed [tcf_pkg::EST_W-1:0]    tilt_x,
    output logic signed [tcf_pkg::EST_W-1:0]    tilt_y
);

    localparam int DEV_W  = tcf_pkg::DEV_W;
    localparam int BIAS_W = tcf_pkg::BIAS_W;
    localparam int CX_W   = tcf_pkg::CX_W;
    localparam int CZ_W   = tcf_pkg::CZ_W;
    localparam int RAD_W  = tcf_pkg::RAD_W;
    localparam int MUL_W  = tcf_pkg::MUL_W;
    localparam int S_W    = tcf_pkg::S_W;
    localparam int SMAG_W = tcf_pkg::SMAG_W;
    localparam int D_W    = tcf_pkg::D_W;
    localparam int SUM_W  = tcf_pkg::SUM_W;
    localparam int LO_W   = 17;
    localparam int LOP_W  = LO_W + tcf_pkg::DT_W;
    localparam int TOT_W  = 2 * MUL_W + 2;

    function automatic logic signed [DEV_W-1:0] dev_of(input logic [tcf_pkg::RAW_W-1:0] raw,
                                                       input logic [BIAS_W-1:0] bias);
        logic [BIAS_W-1:0] scaled;
        scaled = BIAS_W'(raw) * BIAS_W'(tcf_pkg::CAL_SAMPLES);
        return $signed(DEV_W'(scaled)) - $signed(DEV_W'(bias));
    endfunction

    function automatic logic [DEV_W-1:0] mag_of(input logic signed [DEV_W-1:0] v);
        return v[DEV_W-1] ? DEV_W'(-v) : DEV_W'(v);
    endfunction

    function automatic logic signed [CX_W-1:0] shr_trunc(input logic signed [CX_W-1:0] v,
                                                         input logic [4:0] s);
        logic [CX_W-1:0] m;
        m = v[CX_W-1] ? CX_W'(-v) : CX_W'(v);
        m = m >> s;
        return v[CX_W-1] ? -$signed(m) : $signed(m);
    endfunction

    logic [BIAS_W-1:0]              bias_reg [4];
    logic signed [tcf_pkg::EST_W-1:0] est_reg [2];
    logic signed [DEV_W-1:0]        dev_a_reg [2];
    logic signed [DEV_W-1:0]        dev_g_reg [2];
    logic signed [DEV_W-1:0]        dev_z_reg;
    logic [tcf_pkg::TICK_W-1:0]     ticks_reg;
    logic [2*MUL_W-1:0]             mul_reg;
    logic [tcf_pkg::DT_W-1:0]       dt_reg;
    logic [tcf_pkg::SQ_W-1:0]       sumsq_reg;
    logic [RAD_W-1:0]               rad_reg;
    logic [RAD_W-1:0]               root_reg;
    logic [RAD_W-1:0]               sq_bit_reg;
    logic signed [CX_W-1:0]         cx_reg;
    logic signed [CX_W-1:0]         cy_reg;
    logic signed [CZ_W-1:0]         cz_reg;
    logic [tcf_pkg::DIV_W-1:0]      num_reg;
    logic [tcf_pkg::QHI_W-1:0]      qhi_reg;
    logic                           diff_neg_reg;
    logic signed [S_W-1:0]          s_reg;
    logic [LOP_W-1:0]               lo_reg;
    logic [D_W-1:0]                 d_reg;
    logic signed [tcf_pkg::EST_W-1:0] tilt_x_reg;
    logic signed [tcf_pkg::EST_W-1:0] tilt_y_reg;

    logic [MUL_W-1:0]               mul_a;
    logic [MUL_W-1:0]               mul_b;
    logic                           mul_en;
    logic [2*MUL_W-1:0]             mul_p;
    logic signed [CZ_W-1:0]         acc_angle;
    logic signed [CX_W-1:0]         diff;
    logic [CX_W-1:0]                diff_mag;
    logic [SMAG_W-1:0]              s_mag;
    logic [RAD_W:0]                 sq_trial;
    logic [tcf_pkg::QHI_W-1:0]      q_hi;
    logic [tcf_pkg::REM_W-1:0]      rem_dig;
    logic [tcf_pkg::DIV_W-2:0]      term_mag;
    logic signed [S_W-1:0]          term_s;
    logic signed [S_W-1:0]          rate_s;
    logic [TOT_W-1:0]               total;
    logic signed [SUM_W-1:0]        new_est;
    logic signed [tcf_pkg::EST_W-1:0] clamped;
    logic signed [CX_W-1:0]         cx_sh;
    logic signed [CX_W-1:0]         cy_sh;
    logic signed [CZ_W-1:0]         atan_s;

    assign acc_angle = (dev_a_reg[cmd.axis] == '0) ? '0 : cz_reg;
    assign diff      = CX_W'(acc_angle) - CX_W'(est_reg[cmd.axis]);
    assign diff_mag  = diff[CX_W-1] ? CX_W'(-diff) : CX_W'(diff);
    assign s_mag     = s_reg[S_W-1] ? SMAG_W'(-s_reg) : SMAG_W'(s_reg);

    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (cmd.op)
            tcf_pkg::OP_DT: begin
                mul_a = MUL_W'(ticks_reg);
                mul_b = MUL_W'(cfg.tick_seconds);
            end
            tcf_pkg::OP_SQ_B: begin
                mul_a = MUL_W'(mag_of(dev_a_reg[~cmd.axis]));
                mul_b = MUL_W'(mag_of(dev_a_reg[~cmd.axis]));
            end
            tcf_pkg::OP_SQ_C: begin
                mul_a = MUL_W'(mag_of(dev_z_reg));
                mul_b = MUL_W'(mag_of(dev_z_reg));
            end
            tcf_pkg::OP_RATE: begin
                mul_a = MUL_W'(mag_of(dev_g_reg[cmd.axis]));
                mul_b = MUL_W'(cfg.gyro_gain);
            end
            tcf_pkg::OP_DIV: begin
                mul_en = !cmd.step[0];
                mul_a  = cmd.step[1]
                    ? MUL_W'(num_reg[tcf_pkg::DIG_W+tcf_pkg::REM_W-1:0])
                    : MUL_W'(num_reg[tcf_pkg::DIV_W-1:tcf_pkg::DIG_W]);
                mul_b  = MUL_W'(tcf_pkg::RECIP);
            end
            tcf_pkg::OP_OMEGA: begin
                mul_a = MUL_W'(cfg.filter_omega);
                mul_b = MUL_W'(diff_mag);
            end
            tcf_pkg::OP_MUL_LO: begin
                mul_a = MUL_W'(s_mag[LO_W-1:0]);
                mul_b = dt_reg;
            end
            tcf_pkg::OP_MUL_HI: begin
                mul_a = MUL_W'(s_mag[SMAG_W-1:LO_W]);
                mul_b = dt_reg;
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign sq_trial  = (RAD_W+1)'(root_reg) + (RAD_W+1)'(sq_bit_reg);

    assign q_hi    = mul_reg[tcf_pkg::RECIP_SH +: tcf_pkg::QHI_W];
    assign rem_dig = tcf_pkg::REM_W'(num_reg[tcf_pkg::DIV_W-1:tcf_pkg::DIG_W]
                     - tcf_pkg::QHI_W'(q_hi * tcf_pkg::QHI_W'(tcf_pkg::CAL_SAMPLES)));

    assign cx_sh  = shr_trunc(cx_reg, cmd.step[4:0]);
    assign cy_sh  = shr_trunc(cy_reg, cmd.step[4:0]);
    assign atan_s = $signed(CZ_W'(tcf_pkg::atan_entry(cmd.step[4:0])));

    assign term_mag = (tcf_pkg::DIV_W-1)'((48'(mul_reg[46:0]) + 48'h8000) >> 16);
    assign term_s   = diff_neg_reg ? -$signed(S_W'(term_mag)) : $signed(S_W'(term_mag));
    assign rate_s   = dev_g_reg[cmd.axis][DEV_W-1] ? -$signed(S_W'(num_reg))
                                                     : $signed(S_W'(num_reg));

    assign total = TOT_W'(lo_reg) + (TOT_W'(mul_reg[47:0]) << LO_W) + (TOT_W'(1) << 31);

    assign new_est = SUM_W'(est_reg[cmd.axis])
                   + (s_reg[S_W-1] ? -$signed(SUM_W'(d_reg)) : $signed(SUM_W'(d_reg)));

    always_comb begin
        if (new_est > SUM_W'(tcf_pkg::ANGLE_LIMIT)) begin
            clamped = tcf_pkg::EST_W'(tcf_pkg::ANGLE_LIMIT);
        end else if (new_est < -$signed(SUM_W'(tcf_pkg::ANGLE_LIMIT))) begin
            clamped = -$signed(tcf_pkg::EST_W'(tcf_pkg::ANGLE_LIMIT));
        end else begin
            clamped = tcf_pkg::EST_W'(new_est);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) begin
                bias_reg[k] <= '0;
            end
            est_reg[0] <= '0;
            est_reg[1] <= '0;
        end else begin
            if (cmd.calib) begin
                bias_reg[0] <= bias_reg[0] + BIAS_W'(accel_x);
                bias_reg[1] <= bias_reg[1] + BIAS_W'(accel_y);
                bias_reg[2] <= bias_reg[2] + BIAS_W'(rate_x);
                bias_reg[3] <= bias_reg[3] + BIAS_W'(rate_y);
            end
            if (cmd.op == tcf_pkg::OP_COMMIT) begin
                est_reg[cmd.axis] <= clamped;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dev_a_reg[0] <= dev_of(accel_x, bias_reg[0]);
            dev_a_reg[1] <= dev_of(accel_y, bias_reg[1]);
            dev_g_reg[0] <= dev_of(rate_x, bias_reg[2]);
            dev_g_reg[1] <= dev_of(rate_y, bias_reg[3]);
            dev_z_reg    <= ($signed(DEV_W'(accel_z)) - $signed(DEV_W'(cfg.z_offset)))
                            * $signed(DEV_W'(tcf_pkg::CAL_SAMPLES));
            ticks_reg    <= elapsed_ticks;
        end
        if (mul_en) begin
            mul_reg <= mul_p;
        end
        case (cmd.op)
            tcf_pkg::OP_SQ_B: begin
                if (!cmd.axis) begin
                    dt_reg <= mul_reg[tcf_pkg::DT_W-1:0];
                end
            end
            tcf_pkg::OP_SQ_C: sumsq_reg <= mul_reg[tcf_pkg::SQ_W-1:0];
            tcf_pkg::OP_SQRT_LOAD: begin
                rad_reg    <= {tcf_pkg::SQ_W'(sumsq_reg + mul_reg[tcf_pkg::SQ_W-1:0]),
                               16'b0};
                root_reg   <= '0;
                sq_bit_reg <= RAD_W'(1) << (RAD_W - 2);
            end
            tcf_pkg::OP_SQRT: begin
                if (RAD_W'(rad_reg) >= sq_trial) begin
                    rad_reg  <= RAD_W'(rad_reg - sq_trial);
                    root_reg <= (root_reg >> 1) + sq_bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            tcf_pkg::OP_COR_LOAD: begin
                cx_reg <= $signed(CX_W'(root_reg[tcf_pkg::ROOT_W-1:0]));
                cy_reg <= CX_W'(dev_a_reg[cmd.axis]) <<< 8;
                cz_reg <= '0;
            end
            tcf_pkg::OP_COR: begin
                if (cy_reg > 0) begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    cz_reg <= cz_reg + atan_s;
                end else begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    cz_reg <= cz_reg - atan_s;
                end
            end
            tcf_pkg::OP_DIV_LOAD: begin
                num_reg <= tcf_pkg::DIV_W'(mul_reg[MUL_W-1:0])
                         + tcf_pkg::DIV_W'(tcf_pkg::CAL_SAMPLES / 2);
            end
            tcf_pkg::OP_DIV: begin
                if (cmd.step[0]) begin
                    if (!cmd.step[1]) begin
                        qhi_reg <= q_hi;
                        num_reg <= tcf_pkg::DIV_W'({rem_dig,
                                                    num_reg[tcf_pkg::DIG_W-1:0]});
                    end else begin
                        num_reg <= {qhi_reg, mul_reg[tcf_pkg::RECIP_SH +: tcf_pkg::DIG_W]};
                    end
                end
            end
            tcf_pkg::OP_OMEGA: diff_neg_reg <= diff[CX_W-1];
            tcf_pkg::OP_SUM:   s_reg <= term_s + rate_s;
            tcf_pkg::OP_MUL_HI: lo_reg <= mul_reg[LOP_W-1:0];
            tcf_pkg::OP_ROUND: d_reg <= total[TOT_W-1:32];
            default: ;
        endcase
        if (cmd.emit) begin
            tilt_x_reg <= est_reg[0];
            tilt_y_reg <= est_reg[1];
        end
    end

    assign tilt_x = tilt_x_reg;
    assign tilt_y = tilt_y_reg;

endmodule

// ===== hw/rtl/tilt_complementary_filter_unit.sv =====
// Top level of the tilt complementary filter: ports, register file, sequencer, datapath.
// The first CAL_SAMPLES beats only build the bias sums and give no result; the unit stays
// ready for the next one. Each later beat is worked by the shared 32x32 multiplier, the
// 23-step square root, the CORDIC and the reciprocal divide by CAL_SAMPLES, run for
// each axis in turn; the next beat can be taken in the same cycle as the result appears.
// A new beat is taken as soon as the previous result sits in the output register.
module tilt_complementary_filter_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, elapsed_ticks
    input  logic [63:0]                 s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // tilt_x, tilt_y
    output logic [55:0]                 m_tdata,
    input  logic                        cfg_wr_en,
    input  logic [tcf_pkg::IDX_W-1:0]   cfg_wr_index,
    input  logic [tcf_pkg::CFG_W-1:0]   cfg_wr_data
);

    tcf_pkg::tcf_cfg_t                  cfg;
    tcf_pkg::tcf_cmd_t                  cmd;
    logic signed [tcf_pkg::EST_W-1:0]   tilt_x;
    logic signed [tcf_pkg::EST_W-1:0]   tilt_y;

    tcf_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    tcf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tcf_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg           (cfg),
        .accel_x       (s_tdata[9:0]),
        .accel_y       (s_tdata[19:10]),
        .accel_z       (s_tdata[29:20]),
        .rate_x        (s_tdata[39:30]),
        .rate_y        (s_tdata[49:40]),
        .elapsed_ticks (s_tdata[57:50]),
        .tilt_x        (tilt_x),
        .tilt_y        (tilt_y)
    );

    assign m_tdata = {6'b0, tilt_y, tilt_x};

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result loaded over an untaken beat");

    a_busy_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && !cmd.calib) |=> !s_tready)
        else $error("input taken while an item is in work");

    a_tilt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (tilt_x <= 25'sd11796480 && tilt_x >= -25'sd11796480
                      && tilt_y <= 25'sd11796480 && tilt_y >= -25'sd11796480))
        else $error("tilt beyond saturation limit");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the tilt complementary filter unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ticks;
        logic [9:0] rate_y;
        logic [9:0] rate_x;
        logic [9:0] acc_z;
        logic [9:0] acc_y;
        logic [9:0] acc_x;
    } sample_t;

    typedef struct packed {
        logic [24:0] tilt_y;
        logic [24:0] tilt_x;
    } tilt_pair_t;

    localparam longint ARC_TABLE [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 200;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [63:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [tcf_pkg::IDX_W-1:0] cfg_wr_index = tcf_pkg::REG_Z_OFFSET;
    logic [tcf_pkg::CFG_W-1:0] cfg_wr_data = '0;

    tilt_complementary_filter_unit u_dut (.*);

    always #10 aclk = ~aclk;

    // predictor state
    longint unsigned zoff_r = 576, gain_r = 47809, omega_r = 123532, tsec_r = 549756;
    int calib_seen = 0;
    longint unsigned bias_acc [4] = '{0, 0, 0, 0};
    longint est_r [2] = '{0, 0};

    tilt_pair_t tilt_queue [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int tilts_checked = 0;
    int beats_sent = 0;
    int quiet_cycles = 0;

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint trunc_shift(longint v, int s);
        return v < 0 ? -((-v) >>> s) : (v >>> s);
    endfunction

    function automatic longint round_shift(longint v, int s);
        longint m;
        m = (mag(v) + (64'sd1 <<< (s - 1))) >>> s;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint accel_tilt(longint a, longint b, longint c);
        longint x, y, z, nx;
        if (a == 0) return 0;
        x = longint'(int_root(longint'(b * b + c * c) << 16));
        y = a * 256;
        z = 0;
        for (int i = 0; i < tcf_pkg::CORDIC_STEPS && i < 24; i++) begin
            if (y > 0) begin
                nx = x + trunc_shift(y, i);
                y = y - trunc_shift(x, i);
                z = z + ARC_TABLE[i];
            end else begin
                nx = x - trunc_shift(y, i);
                y = y + trunc_shift(x, i);
                z = z - ARC_TABLE[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint gyro_rate(longint dev);
        longint m;
        m = (mag(dev) * longint'(gain_r) + tcf_pkg::CAL_SAMPLES / 2) / tcf_pkg::CAL_SAMPLES;
        return dev < 0 ? -m : m;
    endfunction

    function automatic longint blend(longint e, longint acc, longint rate, longint dt);
        longint s, d, n;
        s = round_shift(longint'(omega_r) * (acc - e), 16) + rate;
        d = round_shift(s * dt, 32);
        n = e + d;
        if (n > tcf_pkg::ANGLE_LIMIT) n = tcf_pkg::ANGLE_LIMIT;
        if (n < -tcf_pkg::ANGLE_LIMIT) n = -tcf_pkg::ANGLE_LIMIT;
        return n;
    endfunction

    task automatic predict_tilt(input sample_t smp);
        longint ax, ay, az, gx, gy, dt;
        tilt_pair_t t;
        if (calib_seen < tcf_pkg::CAL_SAMPLES) begin
            bias_acc[0] = (bias_acc[0] + smp.acc_x) & 16'h3FFF;
            bias_acc[1] = (bias_acc[1] + smp.acc_y) & 16'h3FFF;
            bias_acc[2] = (bias_acc[2] + smp.rate_x) & 16'h3FFF;
            bias_acc[3] = (bias_acc[3] + smp.rate_y) & 16'h3FFF;
            calib_seen++;
            return;
        end
        ax = longint'(smp.acc_x) * tcf_pkg::CAL_SAMPLES - longint'(bias_acc[0]);
        ay = longint'(smp.acc_y) * tcf_pkg::CAL_SAMPLES - longint'(bias_acc[1]);
        az = (longint'(smp.acc_z) - longint'(zoff_r)) * tcf_pkg::CAL_SAMPLES;
        gx = longint'(smp.rate_x) * tcf_pkg::CAL_SAMPLES - longint'(bias_acc[2]);
        gy = longint'(smp.rate_y) * tcf_pkg::CAL_SAMPLES - longint'(bias_acc[3]);
        dt = longint'(smp.ticks) * longint'(tsec_r);
        est_r[0] = blend(est_r[0], accel_tilt(ax, ay, az), gyro_rate(gx), dt);
        est_r[1] = blend(est_r[1], accel_tilt(ay, ax, az), gyro_rate(gy), dt);
        t.tilt_x = est_r[0][24:0];
        t.tilt_y = est_r[1][24:0];
        tilt_queue.push_back(t);
    endtask

    task automatic send_sample(input sample_t smp);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, smp};
        do @(posedge aclk); while (!s_tready);
        predict_tilt(smp);
        beats_sent++;
    endtask

    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tilt_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [tcf_pkg::IDX_W-1:0] idx,
                             input longint unsigned val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val[tcf_pkg::CFG_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            tcf_pkg::REG_Z_OFFSET:     zoff_r = val & 64'h3FF;
            tcf_pkg::REG_GYRO_GAIN:    gain_r = val & 64'h3FFFF;
            tcf_pkg::REG_FILTER_OMEGA: omega_r = val & 64'hFFFFF;
            default:                   tsec_r = val & 64'hFFFFFF;
        endcase
    endtask

    task automatic write_all(input longint unsigned z, g, w, t);
        drain();
        write_reg(tcf_pkg::REG_Z_OFFSET, z);
        write_reg(tcf_pkg::REG_GYRO_GAIN, g);
        write_reg(tcf_pkg::REG_FILTER_OMEGA, w);
        write_reg(tcf_pkg::REG_TICK_SECONDS, t);
    endtask

    function automatic sample_t rand_sample();
        sample_t s;
        s = sample_t'({$urandom, $urandom});
        if ($urandom_range(3) == 0) s.ticks = 8'($urandom_range(8));
        return s;
    endfunction

    // bias build-up: x and y average to 510, gyro means land on whole codes too
    task automatic test_calibration;
        sample_t s;
        for (int i = 0; i < tcf_pkg::CAL_SAMPLES; i++) begin
            s.acc_x = i[0] ? 10'd1020 : 10'd0;
            s.acc_y = i[0] ? 10'd0 : 10'd1020;
            s.acc_z = i[0] ? 10'd1023 : 10'd0;
            s.rate_x = i[0] ? 10'd1020 : 10'd0;
            s.rate_y = i[0] ? 10'd0 : 10'd1020;
            s.ticks = i[0] ? 8'hFF : 8'h00;
            send_sample(s);
        end
    endtask

    task automatic test_directed;
        sample_t s;
        s = '{ticks: 8'd10, rate_y: 10'd510, rate_x: 10'd510, acc_z: 10'd576,
               acc_y: 10'd510, acc_x: 10'd510};
        send_sample(s);
        s.acc_x = 10'd1023;
        s.ticks = 8'd0;
        send_sample(s);
        s = '{ticks: 8'hFF, rate_y: 10'd0, rate_x: 10'd1023, acc_z: 10'd1023,
               acc_y: 10'd0, acc_x: 10'd1023};
        send_sample(s);
        s = '{ticks: 8'hFF, rate_y: 10'd1023, rate_x: 10'd0, acc_z: 10'd0,
               acc_y: 10'd1023, acc_x: 10'd0};
        send_sample(s);
        s.acc_y = 10'd510;
        s.acc_z = 10'd576;
        send_sample(s);
        write_all(1023, 262143, 1048575, 16777215);
        for (int i = 0; i < 4; i++) begin
            s = '{ticks: 8'hFF, rate_y: 10'd1023, rate_x: 10'd1023, acc_z: 10'd0,
                   acc_y: 10'd1023, acc_x: 10'd1023};
            send_sample(s);
        end
        for (int i = 0; i < 4; i++) begin
            s = '{ticks: 8'hFF, rate_y: 10'd0, rate_x: 10'd0, acc_z: 10'd1023,
                   acc_y: 10'd0, acc_x: 10'd0};
            send_sample(s);
        end
        write_all(0, 0, 0, 0);
        send_sample(rand_sample());
        send_sample(rand_sample());
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            case (i * 4 / count)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            send_sample(rand_sample());
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_settings;
        write_all(576, 47809, 123532, 549756);
        test_random(350);
        write_all(1023, 262143, 1048575, 16777215);
        test_random(350);
        write_all(0, 0, 0, 0);
        test_random(350);
        write_all(64'($urandom_range(1023)), 64'($urandom_range(262143)),
                  64'($urandom_range(1048575)), 64'($urandom_range(16777215)));
        test_random(350);
    endtask

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        tilt_pair_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[49:0];
            if (tilt_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected tilt beat %h", got);
            end else begin
                want = tilt_queue.pop_front();
                tilts_checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tilt mismatch: x exp %0d got %0d, y exp %0d got %0d",
                                 $signed(want.tilt_x), $signed(got.tilt_x),
                                 $signed(want.tilt_y), $signed(got.tilt_y));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_calibration();
        test_directed();
        send_idle_pct = 0;
        test_settings();
        drain();
        $display("covered calibration, zero vector, zero step, saturation and four settings");
        $display("%0d beats sent, %0d tilt results checked", beats_sent, tilts_checked);
        if (mismatches == 0 && tilt_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== tilt_complementary_filter_unit.f =====
hw/rtl/tcf_pkg.sv
hw/rtl/tcf_cfg_regs.sv
hw/rtl/tcf_ctrl.sv
hw/rtl/tcf_datapath.sv
hw/rtl/tilt_complementary_filter_unit.sv
test/tb.sv
